// ----- hdl/ckst_pkg.sv -----
`default_nettype none

package ckst_pkg;

  localparam logic [7:0] KEY_ESC   = 8'h1B;
  localparam logic [7:0] KEY_DEL   = 8'h7F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_UPPER_O = 8'h4F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_D = 8'h44;

  localparam int unsigned MAX_BYTES = 5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_e;

  typedef logic [MAX_BYTES-1:0][7:0] seq_t;

  // translated sequence for one request, first byte in entry 0
  typedef struct packed {
    seq_t       bytes;
    logic [2:0] cnt;
    phase_e     phase_next;
  } xlate_t;

  typedef struct packed {
    logic       hit;
    logic       wide;
    logic [7:0] tens;
    logic [7:0] ones;
  } tilde_t;

  // ESC [ n ~ key numbers as ascii digits
  function automatic tilde_t tilde_code(input logic [7:0] c);
    tilde_t t;
    t = '{hit: 1'b1, wide: 1'b0, tens: 8'h30, ones: 8'h30};
    case (c)
      8'h4C: t.ones = 8'h32;
      8'h48: t.ones = 8'h34;
      8'h49: t.ones = 8'h35;
      8'h47: t.ones = 8'h36;
      8'h4D: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h31; end
      8'h4E: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h32; end
      8'h4F: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h33; end
      8'h50: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h34; end
      8'h51: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h35; end
      8'h52: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h37; end
      8'h53: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h38; end
      8'h54: begin t.wide = 1'b1; t.tens = 8'h31; t.ones = 8'h39; end
      8'h55: begin t.wide = 1'b1; t.tens = 8'h32; t.ones = 8'h30; end
      8'h56: begin t.wide = 1'b1; t.tens = 8'h32; t.ones = 8'h31; end
      8'h57: begin t.wide = 1'b1; t.tens = 8'h32; t.ones = 8'h33; end
      8'h58: begin t.wide = 1'b1; t.tens = 8'h32; t.ones = 8'h34; end
      default: t.hit = 1'b0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ckst_xlate.sv -----
`default_nettype none

module ckst_xlate
  import ckst_pkg::*;
(
  input  logic [7:0] byte_i,
  input  logic       eob_i,
  input  phase_e     phase_i,
  input  logic       mode_i,
  output xlate_t     xl_o
);

  logic [3:0][7:0] ib;
  logic [2:0]      icnt;
  phase_e          iphase;
  tilde_t          tc;

  assign tc = tilde_code(byte_i);

  // handling of a byte with nothing pending
  always_comb begin
    ib     = '0;
    icnt   = 3'd0;
    iphase = PH_IDLE;
    if (byte_i == KEY_DEL) begin
      ib   = {CH_TILDE, CH_THREE, CH_LBRACK, KEY_ESC};
      icnt = 3'd4;
    end else if (byte_i == KEY_ESC) begin
      if (eob_i) begin
        ib[0] = KEY_ESC;
        icnt  = 3'd1;
      end else begin
        iphase = PH_ESC;
      end
    end else begin
      ib[0] = byte_i;
      icnt  = 3'd1;
    end
  end

  always_comb begin
    xl_o = '{bytes: '0, cnt: 3'd0, phase_next: PH_IDLE};
    case (phase_i)
      PH_ESC: begin
        if (byte_i == CH_LBRACK) begin
          if (eob_i) begin
            xl_o.bytes[0] = KEY_ESC;
            xl_o.bytes[1] = CH_LBRACK;
            xl_o.cnt      = 3'd2;
          end else begin
            xl_o.phase_next = PH_CSI;
          end
        end else begin
          // held ESC goes out ahead of the byte
          xl_o.bytes      = {ib, KEY_ESC};
          xl_o.cnt        = icnt + 3'd1;
          xl_o.phase_next = iphase;
        end
      end
      PH_CSI: begin
        xl_o.bytes[0] = KEY_ESC;
        if (byte_i >= CH_UPPER_A && byte_i <= CH_UPPER_D) begin
          xl_o.bytes[1] = mode_i ? CH_UPPER_O : CH_LBRACK;
          xl_o.bytes[2] = byte_i;
          xl_o.cnt      = 3'd3;
        end else begin
          xl_o.bytes[1] = CH_LBRACK;
          if (!tc.hit) begin
            xl_o.bytes[2] = byte_i;
            xl_o.cnt      = 3'd3;
          end else if (tc.wide) begin
            xl_o.bytes[2] = tc.tens;
            xl_o.bytes[3] = tc.ones;
            xl_o.bytes[4] = CH_TILDE;
            xl_o.cnt      = 3'd5;
          end else begin
            xl_o.bytes[2] = tc.ones;
            xl_o.bytes[3] = CH_TILDE;
            xl_o.cnt      = 3'd4;
          end
        end
      end
      default: begin
        xl_o.bytes      = {8'h00, ib};
        xl_o.cnt        = icnt;
        xl_o.phase_next = iphase;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/ckst_out.sv -----
`default_nettype none

module ckst_out
  import ckst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  seq_t       bytes_i,
  input  logic [2:0] cnt_i,
  input  logic       eob_i,
  output logic       free_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic       m_axis_tlast,   // last_of_run
  output logic       m_axis_tuser    // buffer_end
);

  seq_t       buf_q, buf_d;
  logic [2:0] rem_q, rem_d;
  logic       eob_q, eob_d;
  logic       pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign free_o        = (rem_q == 3'd0) || (rem_q == 3'd1 && m_axis_tready);
  assign m_axis_tvalid = rem_q != 3'd0;
  assign m_axis_tdata  = buf_q[0];
  assign m_axis_tlast  = rem_q == 3'd1;
  assign m_axis_tuser  = (rem_q == 3'd1) && eob_q;

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    eob_d = eob_q;
    if (pop) begin
      buf_d = {8'h00, buf_q[MAX_BYTES-1:1]};
      rem_d = rem_q - 3'd1;
    end
    if (load_i) begin
      buf_d = bytes_i;
      rem_d = cnt_i;
      eob_d = eob_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    eob_q <= eob_d;
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd5)
    else $error("byte count out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == 3'd0) || (pop && rem_q == 3'd1))
    else $error("load over pending bytes");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i && rem_q == 3'd1) |=> !m_axis_tvalid)
    else $error("output valid after last byte");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !load_i && rem_q > 3'd1) |=> rem_q == $past(rem_q) - 3'd1)
    else $error("byte count did not advance");

endmodule

`default_nettype wire

// ----- hdl/console_key_sequence_translator.sv -----
`default_nettype none

// Console key sequence translator: rewrites a keyboard byte stream into
// VT100-style sequences. DEL becomes ESC [ 3 ~; ESC [ x becomes ESC O x for
// arrows in application cursor mode, ESC [ n ~ for Insert, Home, page keys
// and F1 to F12, and passes through unchanged otherwise. ESC and ESC [ are
// held until the next byte and flushed when s_axis_tlast marks the end of a
// buffer. Each request is translated combinationally into an output buffer
// of up to five bytes, which leaves on the master side one byte per cycle
// while m_axis_tready is high; tlast marks the final byte caused by a request,
// tuser that this request ended a buffer. A request holds the output buffer
// until its bytes have left, and requests that cause no bytes are not loaded;
// the next request can be taken in the same cycle as the last byte of the
// previous one. cfg_data_i[0] sets cursor-key mode (reset 0); the user must
// write it only while the block is idle; the block itself does not enforce it.
module console_key_sequence_translator
  import ckst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,      // app cursor keys
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,    // in_byte
  input  logic       s_axis_tlast,    // end_of_buffer
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // out_byte
  output logic       m_axis_tlast,    // last_of_run
  output logic       m_axis_tuser     // buffer_end
);

  phase_e phase_q, phase_d;
  logic   mode_q, mode_d;
  xlate_t xl;
  logic   accept;
  logic   free;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // translation of the incoming byte against the pending prefix
  ckst_xlate u_xlate (
    .byte_i  (s_axis_tdata),
    .eob_i   (s_axis_tlast),
    .phase_i (phase_q),
    .mode_i  (mode_q),
    .xl_o    (xl)
  );

  // prefix state moves on every accepted request
  assign phase_d = accept ? xl.phase_next : phase_q;
  assign mode_d  = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mode_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
    end
  end

  // output buffer and byte serializer; empty sequences are not loaded
  ckst_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && (xl.cnt != 3'd0)),
    .bytes_i       (xl.bytes),
    .cnt_i         (xl.cnt),
    .eob_i         (s_axis_tlast),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

import ckst_pkg::*;

// one translated byte as it should leave the master side
typedef struct packed {
  logic [7:0] data;
  logic       run_end;   // last byte caused by its request
  logic       buf_end;   // last byte of an end-of-buffer request
} key_out_t;

// tracks escape state and cursor mode, holds the bytes still owed by the block
class key_translation_tracker;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam int unsigned PRINT_CAP = 40;

  logic         cursor_app;
  phase_e       seq_phase;
  key_out_t     expected_bytes[$];
  logic [7:0]   run_bytes[$];
  int unsigned  mismatch_count;
  int unsigned  keys_taken;
  int unsigned  bytes_checked;

  function new();
    cursor_app     = 1'b0;
    seq_phase      = PH_IDLE;
    mismatch_count = 0;
    keys_taken     = 0;
    bytes_checked  = 0;
  endfunction

  task report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // byte seen with nothing pending; a lone ESC is held unless the buffer ends
  function void plain_key(logic [7:0] b, logic eob);
    if (b == KEY_DEL) begin
      run_bytes.push_back(KEY_ESC);
      run_bytes.push_back(CH_LBRACK);
      run_bytes.push_back(CH_THREE);
      run_bytes.push_back(CH_TILDE);
      seq_phase = PH_IDLE;
    end else if (b == KEY_ESC) begin
      if (eob) begin
        run_bytes.push_back(KEY_ESC);
        seq_phase = PH_IDLE;
      end else begin
        seq_phase = PH_ESC;
      end
    end else begin
      run_bytes.push_back(b);
      seq_phase = PH_IDLE;
    end
  endfunction

  // accepted input request: work out the bytes it causes
  function void take_key(logic [7:0] b, logic eob);
    int       n;
    key_out_t e;
    run_bytes = {};
    keys_taken++;
    case (seq_phase)
      PH_ESC: begin
        if (b == CH_LBRACK) begin
          if (eob) begin
            run_bytes.push_back(KEY_ESC);
            run_bytes.push_back(CH_LBRACK);
            seq_phase = PH_IDLE;
          end else begin
            seq_phase = PH_CSI;
          end
        end else begin
          run_bytes.push_back(KEY_ESC);
          plain_key(b, eob);
        end
      end
      PH_CSI: begin
        // third byte is final, never looked at again
        seq_phase = PH_IDLE;
        run_bytes.push_back(KEY_ESC);
        if (b >= CH_UPPER_A && b <= CH_UPPER_D) begin
          run_bytes.push_back(cursor_app ? CH_UPPER_O : CH_LBRACK);
          run_bytes.push_back(b);
        end else begin
          case (b)
            "L": n = 2;
            "H": n = 4;
            "I": n = 5;
            "G": n = 6;
            "M": n = 11;
            "N": n = 12;
            "O": n = 13;
            "P": n = 14;
            "Q": n = 15;
            "R": n = 17;
            "S": n = 18;
            "T": n = 19;
            "U": n = 20;
            "V": n = 21;
            "W": n = 23;
            "X": n = 24;
            default: n = 0;
          endcase
          run_bytes.push_back(CH_LBRACK);
          if (n == 0) begin
            run_bytes.push_back(b);
          end else begin
            if (n >= 10) begin
              run_bytes.push_back(8'(DIGIT_ZERO + n / 10));
            end
            run_bytes.push_back(8'(DIGIT_ZERO + n % 10));
            run_bytes.push_back(CH_TILDE);
          end
        end
      end
      default: plain_key(b, eob);
    endcase
    foreach (run_bytes[k]) begin
      e.data    = run_bytes[k];
      e.run_end = (k == run_bytes.size() - 1);
      e.buf_end = e.run_end && eob;
      expected_bytes.push_back(e);
    end
  endfunction

  // accepted output byte against the oldest one owed
  task check_output(logic [7:0] data, logic run_end, logic buf_end);
    key_out_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("byte %02h came out with nothing owed", data));
    end else begin
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (data !== want.data) begin
        report_mismatch($sformatf("byte %02h, wanted %02h", data, want.data));
      end
      if (run_end !== want.run_end) begin
        report_mismatch($sformatf("tlast %b on byte %02h, wanted %b",
                                  run_end, data, want.run_end));
      end
      if (buf_end !== want.buf_end) begin
        report_mismatch($sformatf("tuser %b on byte %02h, wanted %b",
                                  buf_end, data, want.buf_end));
      end
    end
  endtask
endclass

module testbench;

  localparam int unsigned HOLD_CYCLES   = 300;   // long output stall
  localparam int unsigned SETTLE_CYCLES = 8;     // beyond the combinational translate
  localparam int unsigned DRAIN_LIMIT   = 4000;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i    = 1'b0;   // app cursor keys
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // in_byte
  logic       s_axis_tlast  = 1'b0;   // end_of_buffer
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // out_byte
  logic       m_axis_tlast;           // last_of_run
  logic       m_axis_tuser;           // buffer_end

  key_translation_tracker tracker;

  // flags shared between the stimulus and the output sink
  logic tx_pressure  = 1'b0;   // sender offers back to back
  logic hold_off_req = 1'b0;   // sink holds tready low for a long stretch

  console_key_sequence_translator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // all handshakes seen in one place, so the input is noted before its bytes
  // are checked; values read here are the ones from before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        tracker.cursor_app = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.take_key(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_output(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end
    end
  end

  // output sink: random gaps per byte, steady stretches, one long hold-off
  initial begin : output_sink
    int unsigned gap;
    logic        steady;
    steady = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if ($urandom_range(0, 11) == 0) steady = ~steady;
      gap = steady ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  logic tx_steady = 1'b0;

  // one key byte request; tvalid stays high after the handshake so a
  // following request needs no second assignment in the same step
  task automatic send_key(input logic [7:0] b, input logic eob);
    int unsigned gap;
    if ($urandom_range(0, 11) == 0) tx_steady = ~tx_steady;
    gap = (tx_steady || tx_pressure) ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic buffer_ends();
    return ($urandom_range(0, 7) == 0);
  endfunction

  // random key traffic, mostly well-formed escape sequences, closed by an
  // end-of-buffer byte so nothing is left pending
  task automatic send_random(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  letter;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        // ESC [ key letter, now and then any byte as the final one
        letter = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                             : 8'($urandom_range(CH_UPPER_A, "X"));
        send_key(KEY_ESC, 1'b0);
        send_key(CH_LBRACK, 1'b0);
        send_key(letter, buffer_ends());
        sent += 3;
      end else if (pick < 55) begin
        send_key(KEY_DEL, buffer_ends());
        sent += 1;
      end else if (pick < 65) begin
        // ESC with whatever follows, maybe flushed on its own
        send_key(KEY_ESC, buffer_ends());
        send_key(8'($urandom), buffer_ends());
        sent += 2;
      end else if (pick < 72) begin
        // ESC [ cut off by the end of a buffer
        send_key(KEY_ESC, 1'b0);
        send_key(CH_LBRACK, 1'b1);
        sent += 2;
      end else begin
        send_key(8'($urandom), buffer_ends());
        sent += 1;
      end
    end
    send_key(8'($urandom), 1'b1);
  endtask

  // drop tvalid, wait for every owed byte, then let the block go quiet
  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (tracker.expected_bytes.size() != 0) begin
      tracker.report_mismatch($sformatf("%0d expected bytes never came out",
                                        tracker.expected_bytes.size()));
      tracker.expected_bytes = {};
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mode register write, only with the block idle
  task automatic write_cursor_mode(input logic mode);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= mode;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    tracker = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: byte extremes, DEL, every kind of escape tail in normal cursor mode, flushes
    write_cursor_mode(1'b0);
    send_key(8'h00, 1'b0);
    send_key(8'hFF, 1'b0);
    send_key(KEY_DEL, 1'b0);
    // arrow with normal cursor keys passes as ESC [ A
    send_key(KEY_ESC, 1'b0);
    send_key(CH_LBRACK, 1'b0);
    send_key(CH_UPPER_A, 1'b0);
    // F12, two-digit code, ending a buffer on the final byte
    send_key(KEY_ESC, 1'b0);
    send_key(CH_LBRACK, 1'b0);
    send_key("X", 1'b1);
    // insert, one-digit code
    send_key(KEY_ESC, 1'b0);
    send_key(CH_LBRACK, 1'b0);
    send_key("L", 1'b0);
    // unknown letter passes through unchanged
    send_key(KEY_ESC, 1'b0);
    send_key(CH_LBRACK, 1'b0);
    send_key("Z", 1'b0);
    // DEL as third byte is not expanded
    send_key(KEY_ESC, 1'b0);
    send_key(CH_LBRACK, 1'b0);
    send_key(KEY_DEL, 1'b0);
    // ESC ESC: first goes out, second waits, then ESC not followed by [
    send_key(KEY_ESC, 1'b0);
    send_key(KEY_ESC, 1'b0);
    send_key("x", 1'b0);
    // lone ESC and ESC [ flushed at buffer end
    send_key(KEY_ESC, 1'b1);
    send_key(KEY_ESC, 1'b0);
    send_key(CH_LBRACK, 1'b1);

    // random phases, alternating cursor key mode
    write_cursor_mode(1'b1);
    send_random(20);

    write_cursor_mode(1'b0);
    // sink stalls long while the sender keeps offering: input must back up
    tx_pressure  = 1'b1;
    hold_off_req = 1'b1;
    send_random(10);
    tx_pressure  = 1'b0;
    send_random(10);

    write_cursor_mode(1'b1);
    send_random(20);

    write_cursor_mode(1'b0);
    send_random(20);

    settle();
    $display("checked %0d translated bytes caused by %0d key bytes",
             tracker.bytes_checked, tracker.keys_taken);
    $display("cursor key mode run at 0 and 1, with one %0d-cycle output stall",
             HOLD_CYCLES);
    if (tracker.mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
